### hw/rtl/tcc_pkg.sv
package tcc_pkg;

  // Screen geometry: 64 columns by 64 lines, six bits per coordinate.
  localparam int unsigned CoordBits = 6;
  localparam int unsigned AddrBits  = 2 * CoordBits;
  localparam int unsigned CodeBits  = 8;

  localparam logic [CoordBits-1:0] LastIdx    = 6'd63;
  localparam logic [CoordBits-1:0] ScrollLine = 6'd29;
  localparam logic [CodeBits-1:0]  LineFeed   = 8'd10;

  // Register reset values.
  localparam logic [CodeBits-1:0] EnterCodeReset     = 8'd13;
  localparam logic [CodeBits-1:0] BackspaceCodeReset = 8'd8;

  // APB register map, indexed by the word address.
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 32;

  typedef enum logic {
    REG_ENTER_CODE     = 1'b0,
    REG_BACKSPACE_CODE = 1'b1
  } reg_idx_t;

  // Stream payload widths (padded to whole bytes).
  localparam int unsigned InDataBits  = 16;
  localparam int unsigned OutDataBits = 32;

  // Cursor and scroll state.
  typedef struct packed {
    logic [CoordBits-1:0] col;
    logic [CoordBits-1:0] line;
    logic [CoordBits-1:0] offset;
    logic                 scroll_on;
  } cursor_state_t;

  // Programmable control codes.
  typedef struct packed {
    logic [CodeBits-1:0] enter_code;
    logic [CodeBits-1:0] backspace_code;
  } console_cfg_t;

  // One character-memory write request.
  typedef struct packed {
    logic [CoordBits-1:0] scroll_value;
    logic [CodeBits-1:0]  write_data;
    logic [AddrBits-1:0]  write_addr;
    logic                 write_enable;
  } console_result_t;

endpackage

### hw/rtl/text_console_cursor_scroll.sv
// An accepted character's result beat is registered. Throughput: one character per cycle
// when not back-pressured; the cursor update is a single pass of short logic into the state
// registers, and the output register frees up in the cycle its beat is taken.
// Reset (rst, synchronous): cursor, scroll offset and scroll enable clear to zero,
// enter_code returns to 13, backspace_code to 8, and the output register empties.
module text_console_cursor_scroll (
  input  logic                                clk,
  input  logic                                rst,
  // Character stream in.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] char_code, [8] allow_back_wrap, [15:9] zero
  input  logic [tcc_pkg::InDataBits-1:0]      s_tdata,
  // Write request stream out.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] write_enable, [12:1] write_addr, [20:13] write_data, [26:21] scroll_value,
  // [31:27] zero
  output logic [tcc_pkg::OutDataBits-1:0]     m_tdata,
  // APB configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcc_pkg::CfgAddrBits-1:0]     paddr,
  input  logic [tcc_pkg::CfgDataBits-1:0]     pwdata,
  output logic [tcc_pkg::CfgDataBits-1:0]     prdata,
  output logic                                pready
);
  import tcc_pkg::*;

  cursor_state_t   state;
  cursor_state_t   state_next;
  console_cfg_t    cfg;
  console_result_t step_result;
  console_result_t out_reg;
  logic            out_valid;
  logic            in_beat;
  logic            is_newline;
  reg_idx_t        reg_sel;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_code     <= EnterCodeReset;
      cfg.backspace_code <= BackspaceCodeReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_ENTER_CODE:     cfg.enter_code     <= pwdata[CodeBits-1:0];
        REG_BACKSPACE_CODE: cfg.backspace_code <= pwdata[CodeBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ENTER_CODE:     prdata[CodeBits-1:0] = cfg.enter_code;
      REG_BACKSPACE_CODE: prdata[CodeBits-1:0] = cfg.backspace_code;
      default: ;
    endcase
  end

  // Handshake: take a new beat whenever the output register is empty or being drained.
  assign s_tready = !out_valid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  tcc_step u_step (
    .state           (state),
    .cfg             (cfg),
    .char_code       (s_tdata[CodeBits-1:0]),
    .allow_back_wrap (s_tdata[CodeBits]),
    .state_next      (state_next),
    .result          (step_result),
    .is_newline      (is_newline)
  );

  // Cursor and scroll state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_beat) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_reg <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataBits - $bits(console_result_t)){1'b0}}, out_reg};

  // Every accepted character yields a result beat in the next cycle.
  assert property (@(posedge clk) disable iff (rst) in_beat |=> m_tvalid)
    else $error("accepted character produced no result beat");

  // Scrolling never turns off once enabled.
  assert property (@(posedge clk) disable iff (rst) !$fell(state.scroll_on))
    else $error("scroll enable dropped without reset");

  // Cursor state moves only on an accepted character.
  assert property (@(posedge clk) disable iff (rst) !in_beat |=> $stable(state))
    else $error("cursor state changed without an input beat");

  // A newline always returns the cursor to column zero.
  assert property (@(posedge clk) disable iff (rst) (in_beat && is_newline) |=> state.col == '0)
    else $error("newline left the cursor away from column zero");

  // A no-write result carries zero address and data.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_reg.write_enable) |-> (out_reg.write_addr == '0 && out_reg.write_data == '0))
    else $error("newline result carries a nonzero address or data");

endmodule

### hw/rtl/tcc_step.sv
module tcc_step (
  input  tcc_pkg::cursor_state_t   state,
  input  tcc_pkg::console_cfg_t    cfg,
  input  logic [7:0]               char_code,
  input  logic                     allow_back_wrap,
  output tcc_pkg::cursor_state_t   state_next,
  output tcc_pkg::console_result_t result,
  output logic                     is_newline
);
  import tcc_pkg::*;

  logic                 is_backspace;
  logic [CoordBits-1:0] adv_offset;
  logic [CoordBits-1:0] line_plus;
  logic [CoordBits-1:0] line_minus;
  cursor_state_t        upd;

  // Classify the code: newline has priority over backspace.
  assign is_newline   = (char_code == cfg.enter_code) || (char_code == LineFeed);
  assign is_backspace = !is_newline && (char_code == cfg.backspace_code);

  assign line_plus  = state.line + 1'b1;
  assign line_minus = state.line - 1'b1;

  // Offset update when the cursor advances a line.
  always_comb begin
    if (state.offset == LastIdx) begin
      adv_offset = '0;
    end else if (state.scroll_on) begin
      adv_offset = state.offset + 1'b1;
    end else begin
      adv_offset = state.offset;
    end
  end

  // Cursor movement and the cell write for this character.
  always_comb begin
    upd = state;
    result = '0;
    if (is_newline) begin
      upd.col    = '0;
      upd.line   = line_plus;
      upd.offset = adv_offset;
    end else if (is_backspace) begin
      if (state.col == '0) begin
        if (allow_back_wrap) begin
          upd.col  = LastIdx;
          upd.line = line_minus;
          if (state.scroll_on) begin
            upd.offset = state.offset - 1'b1;
          end
        end
      end else begin
        upd.col = state.col - 1'b1;
      end
      result.write_enable = 1'b1;
      result.write_addr   = {upd.line, upd.col};
      result.write_data   = '0;
    end else begin
      result.write_enable = 1'b1;
      result.write_addr   = {state.line, state.col};
      result.write_data   = char_code;
      if (state.col == LastIdx) begin
        upd.col    = '0;
        upd.line   = line_plus;
        upd.offset = adv_offset;
      end else begin
        upd.col = state.col + 1'b1;
      end
    end
    // Scrolling latches on once the cursor reaches the trigger line.
    if (upd.line == ScrollLine) begin
      upd.scroll_on = 1'b1;
    end
    result.scroll_value = upd.offset;
  end

  assign state_next = upd;

endmodule
